### rtl/htid_pkg.sv
// Shared types and constants for the handheld timer and interrupt dispatch core.
// No dependencies; imported by every module of the block.
package htid_pkg;

    // field widths
    localparam int CYC_W   = 5;
    localparam int LINE_W  = 5;
    localparam int CNT_W   = 8;
    localparam int VEC_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_TICK_W = 9;
    localparam int TMR_TICK_W = 11;

    // modeled request lines and the mask that keeps them
    localparam int IRQ_LINES = 5;
    localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((1 << IRQ_LINES) - 1);

    // timing constants
    localparam logic [CYC_W-1:0]      MAX_CYCLES  = 5'd16;
    localparam logic [DIV_TICK_W-1:0] DIV_PERIOD  = 9'd256;
    localparam logic [TMR_TICK_W-1:0] TMR_RESET   = 11'd1024;
    localparam logic [CNT_W-1:0]      CNT_MAX     = 8'd255;

    // interrupt constants
    localparam int TIMER_LINE = 2;
    localparam logic [VEC_W-1:0] VECTOR_BASE = 8'h40;
    localparam int VECTOR_STEP = 8;

    // master enable control codes
    localparam logic [1:0] IME_NONE   = 2'd0;
    localparam logic [1:0] IME_SET    = 2'd1;
    localparam logic [1:0] IME_CLEAR  = 2'd2;
    localparam logic [1:0] IME_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TMR_ON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN = 2'd3;

    // timer rate selector codes
    localparam logic [1:0] RATE_1024 = 2'd0;
    localparam logic [1:0] RATE_16   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_256  = 2'd3;

    // timer and divider state after one item
    typedef struct packed {
        logic [CNT_W-1:0] div_count;
        logic [CNT_W-1:0] timer_count;
        logic             timer_irq;
    } tmr_status_t;

    // interrupt state after one item
    typedef struct packed {
        logic [LINE_W-1:0] pending;
        logic              dispatch;
        logic [VEC_W-1:0]  vector;
        logic              master_enable;
    } irq_status_t;

    // timer period for a rate selector
    function automatic logic [TMR_TICK_W-1:0] rate_period(input logic [1:0] sel);
        logic [TMR_TICK_W-1:0] p;
        unique case (sel)
            RATE_1024: p = 11'd1024;
            RATE_16:   p = 11'd16;
            RATE_64:   p = 11'd64;
            RATE_256:  p = 11'd256;
            default:   p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

### rtl/handheld_timer_and_irq_dispatch_core.sv
// Top level of the handheld timer and interrupt dispatch core.
// Depends on htid_pkg, htid_timer and htid_irq.
//
// Usage:
//   One input item per executed instruction: cycles, ext_requests, ime_control.
//   An item is taken at a rising edge with in_valid high and in_stall low; a
//   result item is taken with out_valid high and out_stall low.
//   Each item yields exactly one result: divider and timer counts, pending
//   flags, dispatch, vector and master enable after that instruction.
//   An accepted item is first held in the input register; the state update
//   then loads its result into the result register, from which it is
//   offered on the result channel.
//   Throughput is one item per cycle when out_stall is low; the timer and
//   dispatch state loop closes through the tick subtract, compare and priority encode.
//   When the receiver stalls, the result holds in its register and the input
//   register still takes one more item; in_stall rises once both are full.
//   Reset clears both valid bits, all configuration registers, the pending
//   flags and master enable, and loads the tick counters with their periods.
//   Configuration writes take effect at the next edge; the user must make
//   them only while no item is in flight, which the block does not enforce.
module handheld_timer_and_irq_dispatch_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [htid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [htid_pkg::CFG_W-1:0]    cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [htid_pkg::CYC_W-1:0]    cycles,
    input  logic [htid_pkg::LINE_W-1:0]   ext_requests,
    input  logic [1:0]                    ime_control,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [htid_pkg::CNT_W-1:0]    div_value,
    output logic [htid_pkg::CNT_W-1:0]    counter_value,
    output logic [htid_pkg::LINE_W-1:0]   pending_flags,
    output logic                          dispatch,
    output logic [htid_pkg::VEC_W-1:0]    vector,
    output logic                          master_enable
);
    import htid_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]  reload_value_reg;
    logic              timer_on_reg;
    logic [1:0]        rate_select_reg;
    logic [LINE_W-1:0] irq_enable_mask_reg;

    // input register
    logic              in_valid_reg;
    logic [CYC_W-1:0]  cycles_reg;
    logic [LINE_W-1:0] ext_reg;
    logic [1:0]        ime_ctl_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  div_value_reg;
    logic [CNT_W-1:0]  counter_value_reg;
    logic [LINE_W-1:0] pending_reg;
    logic              dispatch_reg;
    logic [VEC_W-1:0]  vector_reg;
    logic              master_enable_reg;

    logic              advance;
    logic              in_take;
    tmr_status_t       tmr_st;
    irq_status_t       irq_st;

    // handshake control
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_value_reg    <= '0;
            timer_on_reg        <= 1'b0;
            rate_select_reg     <= RATE_1024;
            irq_enable_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RELOAD: reload_value_reg    <= cfg_data;
                CFG_TMR_ON: timer_on_reg        <= cfg_data[0];
                CFG_RATE:   rate_select_reg     <= cfg_data[1:0];
                CFG_IRQ_EN: irq_enable_mask_reg <= cfg_data[LINE_W-1:0];
                default:    reload_value_reg    <= reload_value_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cycles_reg  <= cycles;
            ext_reg     <= ext_requests;
            ime_ctl_reg <= ime_control;
        end
    end

    // divider and timer
    htid_timer u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .cycles       (cycles_reg),
        .timer_on     (timer_on_reg),
        .rate_select  (rate_select_reg),
        .reload_value (reload_value_reg),
        .status       (tmr_st)
    );

    // interrupt flags and dispatch
    htid_irq u_irq (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (advance),
        .ext_requests    (ext_reg),
        .ime_control     (ime_ctl_reg),
        .timer_irq       (tmr_st.timer_irq),
        .irq_enable_mask (irq_enable_mask_reg),
        .status          (irq_st)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_value_reg     <= tmr_st.div_count;
            counter_value_reg <= tmr_st.timer_count;
            pending_reg       <= irq_st.pending;
            dispatch_reg      <= irq_st.dispatch;
            vector_reg        <= irq_st.vector;
            master_enable_reg <= irq_st.master_enable;
        end
    end

    assign out_valid     = out_valid_reg;
    assign div_value     = div_value_reg;
    assign counter_value = counter_value_reg;
    assign pending_flags = pending_reg;
    assign dispatch      = dispatch_reg;
    assign vector        = vector_reg;
    assign master_enable = master_enable_reg;

endmodule

### rtl/htid_timer.sv
// Divider and selectable-rate timer counter, advanced once per item.
// Depends on htid_pkg.
module htid_timer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic [htid_pkg::CYC_W-1:0] cycles,
    input  logic                       timer_on,
    input  logic [1:0]                 rate_select,
    input  logic [htid_pkg::CNT_W-1:0] reload_value,
    output htid_pkg::tmr_status_t      status
);
    import htid_pkg::*;

    logic [DIV_TICK_W-1:0] div_ticks_reg, div_ticks_next;
    logic [TMR_TICK_W-1:0] tmr_ticks_reg, tmr_ticks_next;
    logic [CNT_W-1:0]      div_count_reg, div_count_next;
    logic [CNT_W-1:0]      tmr_count_reg, tmr_count_next;

    logic [CYC_W-1:0]      cyc_sat;
    logic [DIV_TICK_W:0]   div_diff;
    logic [TMR_TICK_W:0]   tmr_diff;
    logic                  div_expired;
    logic                  tmr_expired;
    logic                  ovf;

    // saturate cycles, then take them off both tick counters
    always_comb
    begin
        cyc_sat     = (cycles > MAX_CYCLES) ? MAX_CYCLES : cycles;
        div_diff    = {1'b0, div_ticks_reg} - (DIV_TICK_W+1)'(cyc_sat);
        tmr_diff    = {1'b0, tmr_ticks_reg} - (TMR_TICK_W+1)'(cyc_sat);
        div_expired = div_diff[DIV_TICK_W] || (div_diff == '0);
        tmr_expired = tmr_diff[TMR_TICK_W] || (tmr_diff == '0);
    end

    // divider
    always_comb
    begin
        if (div_expired)
        begin
            div_ticks_next = DIV_TICK_W'(div_diff + (DIV_TICK_W+1)'(DIV_PERIOD));
            div_count_next = div_count_reg + 8'd1;
        end
        else
        begin
            div_ticks_next = div_diff[DIV_TICK_W-1:0];
            div_count_next = div_count_reg;
        end
    end

    // timer counter with reload on wrap
    always_comb
    begin
        tmr_ticks_next = tmr_ticks_reg;
        tmr_count_next = tmr_count_reg;
        ovf            = 1'b0;
        if (timer_on)
        begin
            if (tmr_expired)
            begin
                tmr_ticks_next = TMR_TICK_W'(tmr_diff
                                 + (TMR_TICK_W+1)'(rate_period(rate_select)));
                if (tmr_count_reg == CNT_MAX)
                begin
                    tmr_count_next = reload_value;
                    ovf            = 1'b1;
                end
                else
                begin
                    tmr_count_next = tmr_count_reg + 8'd1;
                end
            end
            else
            begin
                tmr_ticks_next = tmr_diff[TMR_TICK_W-1:0];
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_ticks_reg <= DIV_PERIOD;
            tmr_ticks_reg <= TMR_RESET;
            div_count_reg <= '0;
            tmr_count_reg <= '0;
        end
        else if (step_en)
        begin
            div_ticks_reg <= div_ticks_next;
            tmr_ticks_reg <= tmr_ticks_next;
            div_count_reg <= div_count_next;
            tmr_count_reg <= tmr_count_next;
        end
    end

    assign status.div_count   = div_count_next;
    assign status.timer_count = tmr_count_next;
    assign status.timer_irq   = ovf;

endmodule

### rtl/htid_irq.sv
// Pending request flags, master enable and lowest-line-first dispatch.
// Depends on htid_pkg.
module htid_irq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [htid_pkg::LINE_W-1:0] ext_requests,
    input  logic [1:0]                  ime_control,
    input  logic                        timer_irq,
    input  logic [htid_pkg::LINE_W-1:0] irq_enable_mask,
    output htid_pkg::irq_status_t       status
);
    import htid_pkg::*;

    logic [LINE_W-1:0] flags_reg, flags_next;
    logic              ime_reg, ime_next;

    logic [LINE_W-1:0] flags_mid;
    logic [LINE_W-1:0] timer_bit;
    logic [LINE_W-1:0] ready;
    logic              ime_mid;
    logic              found;
    logic [VEC_W-1:0]  vec;

    // apply master enable change and merge new requests
    always_comb
    begin
        unique case (ime_control)
            IME_SET:    ime_mid = 1'b1;
            IME_CLEAR:  ime_mid = 1'b0;
            IME_NONE,
            IME_UNUSED: ime_mid = ime_reg;
            default:    ime_mid = ime_reg;
        endcase
        timer_bit = '0;
        timer_bit[TIMER_LINE] = timer_irq;
        flags_mid = (flags_reg | ext_requests | timer_bit) & LINE_MASK;
        ready     = ime_mid ? (flags_mid & irq_enable_mask & LINE_MASK) : '0;
    end

    // dispatch the lowest ready line
    always_comb
    begin
        found      = 1'b0;
        vec        = '0;
        flags_next = flags_mid;
        ime_next   = ime_mid;
        for (int i = 0; i < LINE_W; i++)
        begin
            if (!found && ready[i])
            begin
                found         = 1'b1;
                flags_next[i] = 1'b0;
                ime_next      = 1'b0;
                vec           = VECTOR_BASE + VEC_W'(VECTOR_STEP * i);
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            ime_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            flags_reg <= flags_next;
            ime_reg   <= ime_next;
        end
    end

    assign status.pending       = flags_next;
    assign status.dispatch      = found;
    assign status.vector        = vec;
    assign status.master_enable = ime_next;

endmodule

### verif/testbench.sv
// Self-checking testbench for handheld_timer_and_irq_dispatch_core.
// Depends on htid_pkg and the core RTL; it predicts every result item and
// checks it against the block through the valid/stall channels.
module testbench;

    import htid_pkg::*;

    localparam int LATENCY     = 2;
    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 2000;

    // one expected result item
    typedef struct packed {
        logic [CNT_W-1:0]  div_value;
        logic [CNT_W-1:0]  counter_value;
        logic [LINE_W-1:0] pending;
        logic              dispatch;
        logic [VEC_W-1:0]  vector;
        logic              master_enable;
    } instr_status_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CYC_W-1:0]     cycles;
    logic [LINE_W-1:0]    ext_requests;
    logic [1:0]           ime_control;
    logic                 out_valid;
    logic                 out_stall;
    logic [CNT_W-1:0]     div_value;
    logic [CNT_W-1:0]     counter_value;
    logic [LINE_W-1:0]    pending_flags;
    logic                 dispatch;
    logic [VEC_W-1:0]     vector;
    logic                 master_enable;

    // predictor copy of configuration and state
    logic [CNT_W-1:0]  model_reload;
    logic              model_timer_on;
    logic [1:0]        model_rate;
    logic [LINE_W-1:0] model_irq_en;
    int                div_ticks_left;
    int                timer_ticks_left;
    logic [CNT_W-1:0]  div_count;
    logic [CNT_W-1:0]  timer_count;
    logic [LINE_W-1:0] req_flags;
    logic              ime;

    instr_status_t status_queue[$];
    int  mismatches   = 0;
    int  idle_cycles  = 0;
    bit  send_gaps_on = 1'b1;
    bit  recv_gaps_on = 1'b1;
    bit  hold_request = 1'b0;

    handheld_timer_and_irq_dispatch_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cycles        (cycles),
        .ext_requests  (ext_requests),
        .ime_control   (ime_control),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .div_value     (div_value),
        .counter_value (counter_value),
        .pending_flags (pending_flags),
        .dispatch      (dispatch),
        .vector        (vector),
        .master_enable (master_enable)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // advance the predicted timer and interrupt state by one instruction
    task automatic predict_status(input logic [CYC_W-1:0] cyc_in,
                                  input logic [LINE_W-1:0] ext,
                                  input logic [1:0] ctl,
                                  output instr_status_t s);
        int                cyc;
        int                period;
        logic [LINE_W-1:0] ready;
        cyc = (cyc_in > MAX_CYCLES) ? int'(MAX_CYCLES) : int'(cyc_in);
        if (ctl == IME_SET)
            ime = 1'b1;
        else if (ctl == IME_CLEAR)
            ime = 1'b0;
        req_flags = (req_flags | ext) & LINE_MASK;

        // divider
        div_ticks_left = div_ticks_left - cyc;
        if (div_ticks_left <= 0)
        begin
            div_ticks_left = div_ticks_left + int'(DIV_PERIOD);
            div_count = div_count + 1'b1;
        end

        // selectable-rate timer, period picked at expiry
        if (model_timer_on)
        begin
            timer_ticks_left = timer_ticks_left - cyc;
            if (timer_ticks_left <= 0)
            begin
                case (model_rate)
                    RATE_16:  period = 16;
                    RATE_64:  period = 64;
                    RATE_256: period = 256;
                    default:  period = 1024;
                endcase
                timer_ticks_left = timer_ticks_left + period;
                if (timer_count == CNT_MAX)
                begin
                    timer_count = model_reload;
                    req_flags = req_flags | (LINE_MASK & LINE_W'(1 << TIMER_LINE));
                end
                else
                    timer_count = timer_count + 1'b1;
            end
        end

        // lowest pending and enabled line wins
        s.dispatch = 1'b0;
        s.vector   = '0;
        if (ime)
        begin
            ready = req_flags & model_irq_en & LINE_MASK;
            for (int ln = 0; ln < IRQ_LINES; ln++)
            begin
                if (!s.dispatch && ready[ln])
                begin
                    ime           = 1'b0;
                    req_flags[ln] = 1'b0;
                    s.dispatch    = 1'b1;
                    s.vector      = VEC_W'(int'(VECTOR_BASE) + VECTOR_STEP * ln);
                end
            end
        end
        s.div_value     = div_count;
        s.counter_value = timer_count;
        s.pending       = req_flags;
        s.master_enable = ime;
    endtask

    task automatic check_field(input string field, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    // check result items and predict accepted input items
    always @(posedge clk)
    begin : status_monitor
        instr_status_t exp_s;
        bit            progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                if (status_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item expected none, actual div=%0d cnt=%0d",
                             $time, div_value, counter_value);
                end
                else
                begin
                    exp_s = status_queue.pop_front();
                    check_field("div_value", exp_s.div_value, div_value);
                    check_field("counter_value", exp_s.counter_value, counter_value);
                    check_field("pending_flags", 8'(exp_s.pending), 8'(pending_flags));
                    check_field("dispatch", 8'(exp_s.dispatch), 8'(dispatch));
                    check_field("vector", exp_s.vector, vector);
                    check_field("master_enable", 8'(exp_s.master_enable),
                                8'(master_enable));
                end
            end
            if (in_valid && !in_stall)
            begin
                progress = 1'b1;
                predict_status(cycles, ext_requests, ime_control, exp_s);
                status_queue.push_back(exp_s);
            end
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
    end

    // receiver: random stall bursts, or one long hold on request
    initial
    begin : result_receiver
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (recv_gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL handheld_timer_and_irq_dispatch_core");
        $finish;
    end

    // send one instruction item, called and returning at a falling edge
    task automatic send_instr(input logic [CYC_W-1:0] cyc, input logic [LINE_W-1:0] ext,
                              input logic [1:0] ctl);
        if (send_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        cycles       <= cyc;
        ext_requests <= ext;
        ime_control  <= ctl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // random instruction, optionally biased to long instructions
    task automatic send_random(input bit long_cycles);
        logic [CYC_W-1:0]  cyc;
        logic [LINE_W-1:0] ext;
        logic [1:0]        ctl;
        if (long_cycles && $urandom_range(0, 9) != 0)
            cyc = ($urandom_range(0, 3) == 0) ? CYC_W'($urandom_range(17, 31)) : MAX_CYCLES;
        else
        begin
            case ($urandom_range(0, 9))
                0:       cyc = '0;
                1:       cyc = CYC_W'($urandom_range(17, 31));
                default: cyc = CYC_W'($urandom_range(1, 16));
            endcase
        end
        ext = ($urandom_range(0, 3) == 0) ? LINE_W'($urandom_range(0, 31)) : '0;
        case ($urandom_range(0, 9))
            6, 7:    ctl = IME_SET;
            8:       ctl = IME_CLEAR;
            9:       ctl = IME_UNUSED;
            default: ctl = IME_NONE;
        endcase
        send_instr(cyc, ext, ctl);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // write all registers, only while idle
    task automatic configure(input logic [CNT_W-1:0] reload, input logic on,
                             input logic [1:0] rate, input logic [LINE_W-1:0] mask);
        write_reg(CFG_RELOAD, CFG_W'(reload));
        write_reg(CFG_TMR_ON, CFG_W'(on));
        write_reg(CFG_RATE, CFG_W'(rate));
        write_reg(CFG_IRQ_EN, CFG_W'(mask));
        cfg_we <= 1'b0;
        model_reload   = reload;
        model_timer_on = on;
        model_rate     = rate;
        model_irq_en   = mask;
    endtask

    // stop sending and wait for every expected result item
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (status_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // register defaults: divider only, saturation, masked requests
    task automatic test_reset_defaults();
        send_instr(5'd0, 5'h00, IME_NONE);
        send_instr(5'd16, 5'h00, IME_NONE);
        send_instr(5'd31, 5'h1F, IME_SET);
        send_instr(5'd17, 5'h00, IME_UNUSED);
        send_instr(5'd8, 5'h00, IME_CLEAR);
        wait_idle();
    endtask

    // master enable codes and dispatch priority
    task automatic test_ime_and_priority();
        configure(8'h00, 1'b0, RATE_1024, 5'h1F);
        send_instr(5'd4, 5'h00, IME_NONE);
        repeat (5) send_instr(5'd4, 5'h00, IME_SET);
        send_instr(5'd4, 5'h00, IME_SET);
        send_instr(5'd4, 5'h08, IME_NONE);
        send_instr(5'd4, 5'h01, IME_CLEAR);
        send_instr(5'd4, 5'h00, IME_UNUSED);
        wait_idle();
        configure(8'h00, 1'b0, RATE_1024, 5'h14);
        send_instr(5'd4, 5'h1B, IME_SET);
        wait_idle();
    endtask

    // timer enable, rate change without restart, timer disabled
    task automatic test_timer_basic();
        configure(8'hFF, 1'b1, RATE_16, 5'h1F);
        repeat (3) send_instr(5'd16, 5'h00, IME_NONE);
        send_instr(5'd31, 5'h00, IME_NONE);
        repeat (2) send_instr(5'd1, 5'h00, IME_NONE);
        wait_idle();
        configure(8'h00, 1'b1, RATE_1024, 5'h1F);
        repeat (2) send_instr(5'd16, 5'h00, IME_NONE);
        wait_idle();
        configure(8'h00, 1'b0, RATE_64, 5'h1F);
        repeat (2) send_instr(5'd16, 5'h00, IME_NONE);
        wait_idle();
    endtask

    // fast timer with top reload value: counter wraps and keeps raising line 2
    task automatic test_timer_overflow();
        configure(CNT_MAX, 1'b1, RATE_16, 5'h1F);
        repeat (350) send_random(1'b1);
        wait_idle();
    endtask

    // receiver holds off long enough for the block to fill and stall input
    task automatic test_backpressure();
        send_gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (24) send_random(1'b0);
        wait_idle();
        send_gaps_on = 1'b1;
    endtask

    // random settings per phase with random instruction streams
    task automatic test_random_phases();
        logic [CNT_W-1:0]  reload;
        logic [LINE_W-1:0] mask;
        repeat (10)
        begin
            case ($urandom_range(0, 3))
                0:       reload = '0;
                1:       reload = CNT_MAX;
                2:       reload = CNT_W'($urandom_range(240, 255));
                default: reload = CNT_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 2))
                0:       mask = '0;
                1:       mask = LINE_MASK;
                default: mask = LINE_W'($urandom_range(0, 31));
            endcase
            configure(reload, $urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)), mask);
            send_gaps_on = $urandom_range(0, 2) != 0;
            recv_gaps_on = $urandom_range(0, 2) != 0;
            repeat (100) send_random($urandom_range(0, 3) == 0);
            wait_idle();
        end
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
    endtask

    // back-to-back items with no idling on either side
    task automatic test_steady_stream();
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        configure(CNT_W'($urandom_range(240, 255)), 1'b1, RATE_16, LINE_MASK);
        repeat (180) send_random(1'b0);
        wait_idle();
    endtask

    initial
    begin : main_sequence
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cycles       = '0;
        ext_requests = '0;
        ime_control  = IME_NONE;

        // predictor reset state
        model_reload     = '0;
        model_timer_on   = 1'b0;
        model_rate       = RATE_1024;
        model_irq_en     = '0;
        div_ticks_left   = int'(DIV_PERIOD);
        timer_ticks_left = int'(TMR_RESET);
        div_count        = '0;
        timer_count      = '0;
        req_flags        = '0;
        ime              = 1'b0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_ime_and_priority();
        test_timer_basic();
        test_timer_overflow();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        if (mismatches == 0 && status_queue.size() == 0)
            $display("PASS handheld_timer_and_irq_dispatch_core");
        else
            $display("FAIL handheld_timer_and_irq_dispatch_core");
        $finish;
    end

endmodule
